>>> rtl/core/box_blur_3x3_clamped_edges_core_macros.svh
// Assertion macros for the box blur core, used by the bb3_emit module.
`ifndef BOX_BLUR_3X3_CLAMPED_EDGES_CORE_MACROS_SVH
`define BOX_BLUR_3X3_CLAMPED_EDGES_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BB3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bb3_pkg.sv
// Package of types, constants and functions for the 3x3 box blur core.
`default_nettype none

package bb3_pkg;

    localparam int MAX_SIDE   = 1024;
    localparam int CHAN_W     = 16;
    localparam int ADDR_W     = $clog2(MAX_SIDE);
    localparam int SIDE_W     = ADDR_W + 1;
    localparam int SUM_W      = CHAN_W + 4;
    localparam int MUL_W      = 20;
    localparam int SHIFT_W    = 5;
    localparam int PROD_W     = SUM_W + MUL_W;
    localparam int TQ_DEPTH   = 4;
    localparam int TQ_PTR_W   = $clog2(TQ_DEPTH);
    localparam int TQ_CNT_W   = TQ_PTR_W + 1;
    localparam int WIN_CELLS  = 9;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(512);

    // Result kinds, as bit positions of a request's kind mask
    localparam int KIND_UL = 0;  // row - 1, col - 1
    localparam int KIND_UR = 1;  // row - 1, col
    localparam int KIND_LL = 2;  // row, col - 1
    localparam int KIND_LR = 3;  // row, col (bottom-right corner)

    typedef struct packed {
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
    } pix_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [ADDR_W-1:0] out_row;
        logic [ADDR_W-1:0] out_col;
        logic              run_last;
        logic              frame_last;
    } pix_out_t;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } rgb_t;

    typedef struct packed {
        rgb_t upper;
        rgb_t middle;
    } line_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] row;
        logic [ADDR_W-1:0] col;
        logic [3:0]        kinds;
        rgb_t              px;
    } s1_t;

    typedef struct packed {
        rgb_t [WIN_CELLS-1:0] win;
        logic [ADDR_W-1:0]    row;
        logic [ADDR_W-1:0]    col;
        logic [3:0]           kinds;
    } task_t;

    typedef struct packed {
        logic [MUL_W-1:0]   mul;
        logic [SHIFT_W-1:0] sh;
    } div_t;

    // Reciprocal and shift giving floor(x / n) for x below 2**SUM_W
    function automatic div_t div_consts(input logic [3:0] n);
        div_t d;
        case (n)
            4'd2:    d = '{mul: MUL_W'(1),      sh: SHIFT_W'(1)};
            4'd3:    d = '{mul: MUL_W'(699051), sh: SHIFT_W'(21)};
            4'd4:    d = '{mul: MUL_W'(1),      sh: SHIFT_W'(2)};
            4'd6:    d = '{mul: MUL_W'(699051), sh: SHIFT_W'(22)};
            4'd9:    d = '{mul: MUL_W'(932068), sh: SHIFT_W'(23)};
            default: d = '{mul: MUL_W'(1),      sh: SHIFT_W'(0)};
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/box_blur_3x3_clamped_edges_core.sv
// Top level of the 3x3 clipped box blur core.
//
//  channel | direction | payload              | handshake
//  pix     | in        | pix_in_t (R, G, B)   | pix_valid / pix_ready
//  res     | out       | pix_out_t            | res_valid / res_ready
//  cfg     | in        | frame side, 11 bits  | cfg_valid / cfg_ready
//
// One pixel is taken per cycle while the four-entry request queue has room.
// Results leave through the output register; the output port sets the rate, so the
// bottom row (two results a pixel) and row ends stall the input.
// A result passes the s1 register, the request queue, the sum register and the output register after its last neighbor.
// Reset clears counters and queues and sets the side to 512; the line store needs no clearing pass.
`default_nettype none

module box_blur_3x3_clamped_edges_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      pix_valid,
    output logic                           pix_ready,
    input  bb3_pkg::pix_in_t               pix,
    output logic                           res_valid,
    input  wire logic                      res_ready,
    output bb3_pkg::pix_out_t              res,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [bb3_pkg::SIDE_W-1:0] cfg_data
);
    import bb3_pkg::*;

    logic [SIDE_W-1:0] side_reg;
    logic [SIDE_W-1:0] side_eff;
    logic [ADDR_W-1:0] dm1;
    logic [ADDR_W-1:0] row_reg;
    logic [ADDR_W-1:0] col_reg;
    logic              accept;
    logic [3:0]        kinds;
    s1_t               s1_reg;
    line_t             line_rd;
    logic              line_wr_en;
    logic [ADDR_W-1:0] line_wr_addr;
    line_t             line_wr_data;
    logic              room;
    logic              tq_valid;
    task_t             tq_data;
    logic              tq_pop;

    // Clamp the side to the supported range
    always_comb
    begin
        if (side_reg == '0)
        begin
            side_eff = SIDE_W'(1);
        end
        else if (side_reg > SIDE_W'(MAX_SIDE))
        begin
            side_eff = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side_eff = side_reg;
        end
        dm1 = ADDR_W'(side_eff - SIDE_W'(1));
    end

    assign cfg_ready = 1'b1;
    assign pix_ready = room;
    assign accept    = pix_valid && pix_ready;

    // Find which results this pixel completes
    always_comb
    begin
        kinds[KIND_UL] = (row_reg != '0) && (col_reg != '0);
        kinds[KIND_UR] = (row_reg != '0) && (col_reg == dm1);
        kinds[KIND_LL] = (row_reg == dm1) && (col_reg != '0);
        kinds[KIND_LR] = (row_reg == dm1) && (col_reg == dm1);
    end

    // Advance the raster position; a config write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
            row_reg  <= '0;
            col_reg  <= '0;
            s1_reg   <= '0;
        end
        else
        begin
            s1_reg.valid <= accept;
            // Hold the accepted pixel while its line store read completes
            if (accept)
            begin
                s1_reg.row   <= row_reg;
                s1_reg.col   <= col_reg;
                s1_reg.kinds <= kinds;
                s1_reg.px    <= '{r: pix.in_red, g: pix.in_green, b: pix.in_blue};
            end
            if (cfg_valid && cfg_ready)
            begin
                side_reg <= cfg_data;
                row_reg  <= '0;
                col_reg  <= '0;
            end
            else if (accept)
            begin
                if (col_reg == dm1)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == dm1) ? '0 : row_reg + ADDR_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + ADDR_W'(1);
                end
            end
        end
    end

    bb3_linestore u_linestore (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (line_rd),
        .wr_en   (line_wr_en),
        .wr_addr (line_wr_addr),
        .wr_data (line_wr_data)
    );

    bb3_window u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1           (s1_reg),
        .line_rd      (line_rd),
        .line_wr_en   (line_wr_en),
        .line_wr_addr (line_wr_addr),
        .line_wr_data (line_wr_data),
        .room         (room),
        .tq_valid     (tq_valid),
        .tq_data      (tq_data),
        .tq_pop       (tq_pop)
    );

    bb3_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .tq_valid  (tq_valid),
        .tq_data   (tq_data),
        .tq_pop    (tq_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

`default_nettype wire

>>> rtl/core/bb3_linestore.sv
// Line store memory holding the upper and middle rows, with write forwarding.
`default_nettype none

module bb3_linestore (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [bb3_pkg::ADDR_W-1:0] rd_addr,
    output bb3_pkg::line_t                 rd_data,
    input  wire logic                      wr_en,
    input  wire logic [bb3_pkg::ADDR_W-1:0] wr_addr,
    input  bb3_pkg::line_t                 wr_data
);
    import bb3_pkg::*;

    line_t mem_reg [MAX_SIDE];
    line_t rd_data_reg;
    line_t fwd_data_reg;
    logic  fwd_reg;

    // Read and write the memory
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= mem_reg[rd_addr];
            fwd_data_reg <= wr_data;
        end
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Flag a read that collides with a write to the same entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/bb3_window.sv
// Window shift, line store write-back and request queue toward the emitter.
`default_nettype none

module bb3_window (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  bb3_pkg::s1_t    s1,
    input  bb3_pkg::line_t  line_rd,
    output logic            line_wr_en,
    output logic [bb3_pkg::ADDR_W-1:0] line_wr_addr,
    output bb3_pkg::line_t  line_wr_data,
    output logic            room,
    output logic            tq_valid,
    output bb3_pkg::task_t  tq_data,
    input  wire logic       tq_pop
);
    import bb3_pkg::*;

    rgb_t [WIN_CELLS-1:0] win_reg;
    rgb_t [WIN_CELLS-1:0] win_next;
    task_t                q_reg [TQ_DEPTH];
    logic [TQ_PTR_W-1:0]  wr_ptr_reg;
    logic [TQ_PTR_W-1:0]  rd_ptr_reg;
    logic [TQ_CNT_W-1:0]  cnt_reg;
    logic                 push;

    // Shift the window one column and load the new column
    always_comb
    begin
        for (int q = 0; q < 3; q++)
        begin
            win_next[q * 3]     = win_reg[q * 3 + 1];
            win_next[q * 3 + 1] = win_reg[q * 3 + 2];
        end
        win_next[2] = line_rd.upper;
        win_next[5] = line_rd.middle;
        win_next[8] = s1.px;
    end

    always_ff @(posedge clk)
    begin
        if (s1.valid)
        begin
            win_reg <= win_next;
        end
    end

    // Rotate the rows in the line store
    assign line_wr_en          = s1.valid;
    assign line_wr_addr        = s1.col;
    assign line_wr_data.upper  = line_rd.middle;
    assign line_wr_data.middle = s1.px;

    // Queue a request only for pixels that finish some result
    assign push = s1.valid && (s1.kinds != 4'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{win: win_next, row: s1.row, col: s1.col, kinds: s1.kinds};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + TQ_PTR_W'(1);
            end
            if (tq_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + TQ_PTR_W'(1);
            end
            cnt_reg <= cnt_reg + TQ_CNT_W'(push) - TQ_CNT_W'(tq_pop);
        end
    end

    // Leave space for the pixel in flight and the next one
    assign room     = ({1'b0, cnt_reg} + (TQ_CNT_W + 1)'(s1.valid)) < (TQ_CNT_W + 1)'(TQ_DEPTH);
    assign tq_valid = (cnt_reg != '0);
    assign tq_data  = q_reg[rd_ptr_reg];

endmodule

`default_nettype wire

>>> rtl/core/bb3_emit.sv
// Result emitter: clipped window sums, reciprocal divide and output register.
`default_nettype none
`include "box_blur_3x3_clamped_edges_core_macros.svh"

module bb3_emit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        tq_valid,
    input  bb3_pkg::task_t   tq_data,
    output logic             tq_pop,
    output logic             res_valid,
    input  wire logic        res_ready,
    output bb3_pkg::pix_out_t res
);
    import bb3_pkg::*;

    logic [3:0]        done_reg;
    logic [3:0]        pending;
    logic [3:0]        sel_oh;
    logic [1:0]        kind;
    logic              last;
    logic              en;
    logic              issue;
    logic              rowcur;
    logic              colcur;
    logic [2:0]        rmask;
    logic [2:0]        cmask;
    logic [1:0]        rn;
    logic [1:0]        cn;
    logic [SUM_W-1:0]  sum_r;
    logic [SUM_W-1:0]  sum_g;
    logic [SUM_W-1:0]  sum_b;

    logic              a_valid_reg;
    logic [SUM_W-1:0]  a_r_reg;
    logic [SUM_W-1:0]  a_g_reg;
    logic [SUM_W-1:0]  a_b_reg;
    logic [3:0]        a_n_reg;
    logic [ADDR_W-1:0] a_row_reg;
    logic [ADDR_W-1:0] a_col_reg;
    logic              a_last_reg;
    logic              a_frame_reg;

    div_t              dc;
    logic [PROD_W-1:0] prod_r;
    logic [PROD_W-1:0] prod_g;
    logic [PROD_W-1:0] prod_b;

    logic              out_valid_reg;
    pix_out_t          out_reg;

    // Pick the next result kind of the head request
    always_comb
    begin
        pending = tq_data.kinds & ~done_reg;
        sel_oh  = pending & (~pending + 4'd1);
        case (sel_oh)
            4'b0010: kind = 2'(KIND_UR);
            4'b0100: kind = 2'(KIND_LL);
            4'b1000: kind = 2'(KIND_LR);
            default: kind = 2'(KIND_UL);
        endcase
        last = ((pending & ~sel_oh) == 4'd0);
    end

    assign en     = !out_valid_reg || res_ready;
    assign issue  = tq_valid && en;
    assign tq_pop = issue && last;

    // Clip the window to the frame around the chosen pixel
    always_comb
    begin
        rowcur   = kind[1];
        colcur   = kind[0];
        rmask[0] = !rowcur && (tq_data.row >= ADDR_W'(2));
        rmask[1] = rowcur ? (tq_data.row >= ADDR_W'(1)) : 1'b1;
        rmask[2] = 1'b1;
        cmask[0] = !colcur && (tq_data.col >= ADDR_W'(2));
        cmask[1] = colcur ? (tq_data.col >= ADDR_W'(1)) : 1'b1;
        cmask[2] = 1'b1;
        rn       = 2'(rmask[0]) + 2'(rmask[1]) + 2'd1;
        cn       = 2'(cmask[0]) + 2'(cmask[1]) + 2'd1;
        sum_r    = '0;
        sum_g    = '0;
        sum_b    = '0;
        for (int q = 0; q < 3; q++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (rmask[q] && cmask[j])
                begin
                    sum_r = sum_r + SUM_W'(tq_data.win[q * 3 + j].r);
                    sum_g = sum_g + SUM_W'(tq_data.win[q * 3 + j].g);
                    sum_b = sum_b + SUM_W'(tq_data.win[q * 3 + j].b);
                end
            end
        end
    end

    // Track the kinds already sent for the head request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 4'd0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= issue;
            out_valid_reg <= a_valid_reg;
            if (issue)
            begin
                done_reg <= last ? 4'd0 : (done_reg | sel_oh);
            end
        end
    end

    // Hold the sums and position for the divide stage
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            a_r_reg     <= sum_r;
            a_g_reg     <= sum_g;
            a_b_reg     <= sum_b;
            a_n_reg     <= 4'(rn) * 4'(cn);
            a_row_reg   <= rowcur ? tq_data.row : tq_data.row - ADDR_W'(1);
            a_col_reg   <= colcur ? tq_data.col : tq_data.col - ADDR_W'(1);
            a_last_reg  <= last;
            a_frame_reg <= (kind == 2'(KIND_LR));
        end
    end

    // Divide by the neighbor count through a reciprocal multiply
    always_comb
    begin
        dc     = div_consts(a_n_reg);
        prod_r = (PROD_W'(a_r_reg) * PROD_W'(dc.mul)) >> dc.sh;
        prod_g = (PROD_W'(a_g_reg) * PROD_W'(dc.mul)) >> dc.sh;
        prod_b = (PROD_W'(a_b_reg) * PROD_W'(dc.mul)) >> dc.sh;
    end

    always_ff @(posedge clk)
    begin
        if (en && a_valid_reg)
        begin
            out_reg.out_red    <= prod_r[CHAN_W-1:0];
            out_reg.out_green  <= prod_g[CHAN_W-1:0];
            out_reg.out_blue   <= prod_b[CHAN_W-1:0];
            out_reg.out_row    <= a_row_reg;
            out_reg.out_col    <= a_col_reg;
            out_reg.run_last   <= a_last_reg;
            out_reg.frame_last <= a_frame_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    `BB3_ASSERT_NOW(a_pending, clk, rst_n, tq_valid, pending != 4'd0, "request with no kind left")
    `BB3_ASSERT_NOW(a_frame_run, clk, rst_n, out_valid_reg && out_reg.frame_last, out_reg.run_last, "frame end not run end")
    `BB3_ASSERT_NEXT(a_pop_clear, clk, rst_n, tq_pop, done_reg == 4'd0, "kind mask not cleared on pop")

endmodule

`default_nettype wire
